// ----- sv/sba_pkg.sv -----
// ============================================================================
// sba_pkg
// Shared types and codes for the scoped bump allocator.
// ============================================================================
package sba_pkg;

    // Default geometry
    localparam int CHUNK_BYTES_DEF = 1024;
    localparam int SCOPE_DEPTH_DEF = 16;
    localparam int MAX_CHUNKS_DEF  = 64;

    // Command codes
    typedef enum logic [1:0] {
        CMD_ALLOC = 2'd0,
        CMD_PUSH  = 2'd1,
        CMD_POP   = 2'd2
    } cmd_code_t;

    // Status codes
    typedef enum logic [2:0] {
        ST_OK         = 3'd0,
        ST_ZERO_SIZE  = 3'd1,
        ST_TOO_LARGE  = 3'd2,
        ST_NO_CHUNKS  = 3'd3,
        ST_SCOPE_FULL = 3'd4,
        ST_SCOPE_EMPT = 3'd5
    } status_code_t;

    // Sequencer states
    typedef enum logic {
        SEQ_IDLE = 1'b0,
        SEQ_POP  = 1'b1
    } seq_state_t;

    // Command transfer
    typedef struct packed {
        logic [1:0]  command;
        logic [15:0] size;
    } sba_cmd_t;

    // Response transfer
    typedef struct packed {
        logic [2:0] status;
        logic [5:0] chunk_index;
        logic [9:0] offset;
        logic [3:0] scope_level;
        logic [6:0] chunks_in_use;
    } sba_rsp_t;

endpackage

// ----- sv/scoped_bump_allocator_unit.sv -----
// ============================================================================
// scoped_bump_allocator_unit
// Bump allocator over a chain of chunks with a stack of saved scopes.
// ============================================================================
// Each command transfer yields exactly one response transfer. Allocate and
// push respond straight from the idle state; pop passes through SEQ_POP, since
// the restored scope comes out of the scope stack memory, whose read data is
// registered. So the block takes one command per cycle for allocate and push
// while the response is not stalled, and a pop holds off the next command until
// its response is loaded. The live (top) scope sits in registers; the scope
// stack memory holds the scopes below it, written by push and read back by pop.
// Every entry is written by push before pop reads it, so the memory needs no
// clearing pass after reset. A finished response waits in an output register,
// and the next command is taken in the same cycle it is handed over.
module scoped_bump_allocator_unit #(
    parameter int CHUNK_BYTES = sba_pkg::CHUNK_BYTES_DEF,
    parameter int SCOPE_DEPTH = sba_pkg::SCOPE_DEPTH_DEF,
    parameter int MAX_CHUNKS  = sba_pkg::MAX_CHUNKS_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cmd_valid,
    output logic              cmd_stall,
    input  sba_pkg::sba_cmd_t cmd,
    output logic              rsp_valid,
    input  logic              rsp_stall,
    output sba_pkg::sba_rsp_t rsp
);
    import sba_pkg::*;

    // Internal widths: offsets reach CHUNK_BYTES, counts reach MAX_CHUNKS.
    localparam int OFF_W   = $clog2(CHUNK_BYTES + 1);
    localparam int SUM_W   = OFF_W + 1;
    localparam int CH_W    = $clog2(MAX_CHUNKS);
    localparam int CNT_W   = $clog2(MAX_CHUNKS + 1);
    localparam int LVL_W   = $clog2(SCOPE_DEPTH);
    localparam int ENTRY_W = CH_W + OFF_W;

    // Control and live scope
    seq_state_t       state_reg, state_next;
    logic [LVL_W-1:0] level_reg, level_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [CH_W-1:0]  top_ch_reg, top_ch_next;
    logic [OFF_W-1:0] top_off_reg, top_off_next;

    // Response register
    logic             rsp_valid_reg, rsp_valid_next;
    sba_rsp_t         rsp_reg, rsp_next;

    // Scope stack memory
    logic [ENTRY_W-1:0] stack_mem [SCOPE_DEPTH];
    logic [ENTRY_W-1:0] rd_data_reg;
    logic               wr_en, rd_en;
    logic [LVL_W-1:0]   rd_addr;

    // Allocate datapath
    logic             accept;
    logic             size_zero, size_big, overflow, need_new, at_limit;
    logic [SUM_W-1:0] off_sum;
    logic [OFF_W-1:0] size_off;
    logic [CNT_W-1:0] ch_plus;
    logic [31:0]      top_ch32, top_off32, next_ch32;

    assign accept    = cmd_valid && !cmd_stall;
    assign cmd_stall = (state_reg != SEQ_IDLE) || (rsp_valid_reg && rsp_stall);
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    // Size checks; the sum below is only used once size fits a chunk.
    assign size_zero = (cmd.size == 16'd0);
    assign size_big  = (32'(cmd.size) > CHUNK_BYTES);
    assign size_off  = OFF_W'(cmd.size);
    assign off_sum   = SUM_W'(top_off_reg) + SUM_W'(size_off);
    assign overflow  = (32'(off_sum) > CHUNK_BYTES);
    assign ch_plus   = CNT_W'(top_ch_reg) + CNT_W'(1);
    assign need_new  = (ch_plus >= count_reg);
    assign at_limit  = (32'(count_reg) >= MAX_CHUNKS);

    // Zero-extended views for the fixed-width response fields
    assign top_ch32  = 32'(top_ch_reg);
    assign top_off32 = 32'(top_off_reg);
    assign next_ch32 = 32'(ch_plus);

    always_comb
    begin
        sba_rsp_t r;
        logic     load;
        r              = '0;
        load           = 1'b0;
        state_next     = state_reg;
        level_next     = level_reg;
        count_next     = count_reg;
        top_ch_next    = top_ch_reg;
        top_off_next   = top_off_reg;
        rsp_valid_next = rsp_valid_reg && rsp_stall;
        rsp_next       = rsp_reg;
        wr_en          = 1'b0;
        rd_en          = 1'b0;
        rd_addr        = level_reg - LVL_W'(1);

        case (state_reg)
            SEQ_IDLE:
            begin
                if (accept)
                begin
                    load     = 1'b1;
                    r.status = ST_OK;
                    case (cmd.command)
                        CMD_ALLOC:
                        begin
                            if (size_zero)
                            begin
                                r.status = ST_ZERO_SIZE;
                            end
                            else if (size_big)
                            begin
                                r.status = ST_TOO_LARGE;
                            end
                            else if (!overflow)
                            begin
                                // Fits: bump within the current chunk.
                                r.chunk_index = top_ch32[5:0];
                                r.offset      = top_off32[9:0];
                                top_off_next  = off_sum[OFF_W-1:0];
                            end
                            else if (need_new && at_limit)
                            begin
                                r.status = ST_NO_CHUNKS;
                            end
                            else
                            begin
                                // Advance to the next chunk, appending if none follows.
                                if (need_new)
                                begin
                                    count_next = count_reg + CNT_W'(1);
                                end
                                top_ch_next   = ch_plus[CH_W-1:0];
                                top_off_next  = size_off;
                                r.chunk_index = next_ch32[5:0];
                                r.offset      = 10'd0;
                            end
                        end
                        CMD_PUSH:
                        begin
                            if (32'(level_reg) == SCOPE_DEPTH - 1)
                            begin
                                r.status = ST_SCOPE_FULL;
                            end
                            else
                            begin
                                // Save the live scope; the new top starts as a copy.
                                wr_en      = 1'b1;
                                level_next = level_reg + LVL_W'(1);
                            end
                        end
                        CMD_POP:
                        begin
                            if (level_reg == '0)
                            begin
                                r.status = ST_SCOPE_EMPT;
                            end
                            else
                            begin
                                // Fetch the saved scope; respond once it returns.
                                rd_en      = 1'b1;
                                load       = 1'b0;
                                level_next = level_reg - LVL_W'(1);
                                state_next = SEQ_POP;
                            end
                        end
                        default:
                        begin
                            r.status = ST_OK;
                        end
                    endcase
                end
            end
            SEQ_POP:
            begin
                top_ch_next  = rd_data_reg[ENTRY_W-1:OFF_W];
                top_off_next = rd_data_reg[OFF_W-1:0];
                load         = 1'b1;
                r.status     = ST_OK;
                state_next   = SEQ_IDLE;
            end
            default:
            begin
                state_next = SEQ_IDLE;
            end
        endcase

        if (load)
        begin
            // Report level and chunk count as they stand after the command.
            r.scope_level   = 4'(level_next);
            r.chunks_in_use = 7'(count_next);
            rsp_valid_next  = 1'b1;
            rsp_next        = r;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= SEQ_IDLE;
            level_reg     <= '0;
            count_reg     <= CNT_W'(1);
            top_ch_reg    <= '0;
            top_off_reg   <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            level_reg     <= level_next;
            count_reg     <= count_next;
            top_ch_reg    <= top_ch_next;
            top_off_reg   <= top_off_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rsp_reg <= rsp_next;
    end

    // Scope stack: one write port (push), one registered read port (pop).
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            stack_mem[level_reg] <= {top_ch_reg, top_off_reg};
        end
        if (rd_en)
        begin
            rd_data_reg <= stack_mem[rd_addr];
        end
    end

`ifndef SYNTHESIS
    a_level_range: assert property (@(posedge clk) disable iff (!rst_n)
        32'(level_reg) <= SCOPE_DEPTH - 1)
        else $error("scope level beyond stack depth");

    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg != '0) && (32'(count_reg) <= MAX_CHUNKS))
        else $error("chunk count out of range");

    a_top_in_chain: assert property (@(posedge clk) disable iff (!rst_n)
        CNT_W'(top_ch_reg) < count_reg)
        else $error("live scope points past the chunk chain");

    a_pop_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == SEQ_POP) |-> cmd_stall)
        else $error("command taken while a pop is in flight");

    a_pop_responds: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == SEQ_POP) |=> (rsp_valid && (state_reg == SEQ_IDLE)))
        else $error("pop did not complete with a response");
`endif

endmodule
